@@ hdl/dcs_pkg.sv @@
package dcs_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned FIELD_W = 7;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned POS_W   = 4;

    localparam logic [CHAR_W-1:0] CHAR_DASH = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    localparam logic [POS_W-1:0] POS_SEP1   = 4'd4;
    localparam logic [POS_W-1:0] POS_SEP2   = 4'd7;
    localparam logic [POS_W-1:0] POS_END    = 4'd10;
    localparam logic [POS_W-1:0] POS_SAT    = 4'd11;
    localparam logic [POS_W-1:0] POS_YEAR_LO = 4'd2;

    localparam logic [YEAR_W-1:0] YEAR_LOW_RESET  = 14'd2000;
    localparam logic [YEAR_W-1:0] YEAR_HIGH_RESET = 14'd2100;

    localparam logic [FIELD_W-1:0] MONTHS_PER_YEAR = 7'd12;
    localparam logic [FIELD_W-1:0] MONTH_FEB       = 7'd2;
    localparam logic [FIELD_W-1:0] MONTH_APR       = 7'd4;
    localparam logic [FIELD_W-1:0] MONTH_JUN       = 7'd6;
    localparam logic [FIELD_W-1:0] MONTH_SEP       = 7'd9;
    localparam logic [FIELD_W-1:0] MONTH_NOV       = 7'd11;
    localparam logic [FIELD_W-1:0] DAYS_LONG       = 7'd31;
    localparam logic [FIELD_W-1:0] DAYS_SHORT      = 7'd30;
    localparam logic [FIELD_W-1:0] DAYS_FEB_LEAP   = 7'd29;
    localparam logic [FIELD_W-1:0] DAYS_FEB        = 7'd28;

    // Register indexes of the configuration port.
    typedef enum logic [0:0] {
        CFG_YEAR_LOW  = 1'b0,
        CFG_YEAR_HIGH = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        STATUS_VALID     = 3'd0,
        STATUS_BAD_LEN   = 3'd1,
        STATUS_BAD_SEP   = 3'd2,
        STATUS_BAD_YEAR  = 3'd3,
        STATUS_BAD_MONTH = 3'd4,
        STATUS_BAD_DAY   = 3'd5
    } status_t;

    // Fault bit positions inside digit_faults.
    localparam int unsigned FAULT_YEAR  = 0;
    localparam int unsigned FAULT_MONTH = 1;
    localparam int unsigned FAULT_DAY   = 2;

    // Everything the checker needs once the last character is folded in.
    typedef struct packed {
        logic [POS_W-1:0]   length;
        logic               sep_fault;
        logic [2:0]         digit_faults;
        logic [YEAR_W-1:0]  year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] century;
        logic [FIELD_W-1:0] year_in_century;
    } fields_t;

    typedef struct packed {
        status_t            status;
        logic [YEAR_W-1:0]  year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
    } result_t;

endpackage

@@ hdl/dcs_char_if.sv @@
interface dcs_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

@@ hdl/dcs_result_if.sv @@
interface dcs_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [13:0] year_value;
    logic [6:0]  month_value;
    logic [6:0]  day_value;

    modport source (
        output valid, output status, output year_value, output month_value,
        output day_value, input ready
    );
    modport sink (
        input valid, input status, input year_value, input month_value,
        input day_value, output ready
    );
endinterface

@@ hdl/calendar_date_string_checker_core.sv @@
// A result is registered from the last character held in the input register.
// Throughput: one character per cycle, set by the single accumulate step between the
// input register and the result register; a last character waits while a result is pending.
// Reset (rst_n, asynchronous, active low) clears the parse state and both handshakes
// and loads year_low = 2000, year_high = 2100.
module calendar_date_string_checker_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [13:0] cfg_data,
    dcs_char_if.sink    char_in,
    dcs_result_if.source result_out
);
    import dcs_pkg::*;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;
    logic              out_valid_reg;
    result_t           result_reg;
    logic [YEAR_W-1:0] year_low_reg;
    logic [YEAR_W-1:0] year_high_reg;

    logic              out_free;
    logic              consume;
    fields_t           fields;
    result_t           result;

    // A character that ends no string never waits on the output side.
    assign out_free      = !out_valid_reg || result_out.ready;
    assign consume       = in_valid_reg && (!last_reg || out_free);
    assign char_in.ready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_low_reg  <= YEAR_LOW_RESET;
            year_high_reg <= YEAR_HIGH_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_YEAR_LOW:  year_low_reg  <= cfg_data;
                CFG_YEAR_HIGH: year_high_reg <= cfg_data;
                default:       year_low_reg  <= year_low_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (char_in.ready)
            in_valid_reg <= char_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (char_in.valid && char_in.ready)
        begin
            char_reg <= char_in.char_code;
            last_reg <= char_in.last_char;
        end
    end

    dcs_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (consume),
        .char_code (char_reg),
        .last_char (last_reg),
        .fields    (fields)
    );

    dcs_judge u_judge (
        .fields    (fields),
        .year_low  (year_low_reg),
        .year_high (year_high_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= consume && last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && consume && last_reg)
            result_reg <= result;
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.status      = result_reg.status;
    assign result_out.year_value  = result_reg.year;
    assign result_out.month_value = result_reg.month;
    assign result_out.day_value   = result_reg.day;

endmodule

@@ hdl/dcs_accum.sv @@
module dcs_accum (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [7:0]               char_code,
    input  logic                     last_char,
    output dcs_pkg::fields_t         fields
);
    import dcs_pkg::*;

    logic [POS_W-1:0]   pos_reg;
    logic               sep_fault_reg;
    logic [2:0]         faults_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [FIELD_W-1:0] month_reg;
    logic [FIELD_W-1:0] day_reg;
    logic [FIELD_W-1:0] century_reg;
    logic [FIELD_W-1:0] yic_reg;

    logic               is_digit;
    logic [3:0]         digit;

    assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign digit    = 4'(char_code - CHAR_ZERO);

    function automatic logic [YEAR_W-1:0] times_ten_plus(
        input logic [YEAR_W-1:0] acc,
        input logic [3:0]        d
    );
        return YEAR_W'({acc, 3'b000} + {acc, 1'b0} + YEAR_W'(d));
    endfunction

    // The next state is the folded value of the current character; a last character clears it.
    always_comb
    begin
        fields.length          = (pos_reg < POS_SAT) ? pos_reg + 1'b1 : pos_reg;
        fields.sep_fault       = sep_fault_reg;
        fields.digit_faults    = faults_reg;
        fields.year            = year_reg;
        fields.month           = month_reg;
        fields.day             = day_reg;
        fields.century         = century_reg;
        fields.year_in_century = yic_reg;
        if (pos_reg < POS_SEP1)
        begin
            if (is_digit)
            begin
                fields.year = times_ten_plus(year_reg, digit);
                // The two-digit halves of the year feed the leap-year rule.
                if (pos_reg < POS_YEAR_LO)
                    fields.century = FIELD_W'(times_ten_plus(YEAR_W'(century_reg), digit));
                else
                    fields.year_in_century = FIELD_W'(times_ten_plus(YEAR_W'(yic_reg), digit));
            end
            else
                fields.digit_faults[FAULT_YEAR] = 1'b1;
        end
        else if ((pos_reg == POS_SEP1) || (pos_reg == POS_SEP2))
        begin
            if (char_code != CHAR_DASH)
                fields.sep_fault = 1'b1;
        end
        else if (pos_reg < POS_SEP2)
        begin
            if (is_digit)
                fields.month = FIELD_W'(times_ten_plus(YEAR_W'(month_reg), digit));
            else
                fields.digit_faults[FAULT_MONTH] = 1'b1;
        end
        else if (pos_reg < POS_END)
        begin
            if (is_digit)
                fields.day = FIELD_W'(times_ten_plus(YEAR_W'(day_reg), digit));
            else
                fields.digit_faults[FAULT_DAY] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            sep_fault_reg <= 1'b0;
            faults_reg    <= '0;
            year_reg      <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            century_reg   <= '0;
            yic_reg       <= '0;
        end
        else if (step)
        begin
            if (last_char)
            begin
                pos_reg       <= '0;
                sep_fault_reg <= 1'b0;
                faults_reg    <= '0;
                year_reg      <= '0;
                month_reg     <= '0;
                day_reg       <= '0;
                century_reg   <= '0;
                yic_reg       <= '0;
            end
            else
            begin
                pos_reg       <= fields.length;
                sep_fault_reg <= fields.sep_fault;
                faults_reg    <= fields.digit_faults;
                year_reg      <= fields.year;
                month_reg     <= fields.month;
                day_reg       <= fields.day;
                century_reg   <= fields.century;
                yic_reg       <= fields.year_in_century;
            end
        end
    end

endmodule

@@ hdl/dcs_judge.sv @@
module dcs_judge (
    input  dcs_pkg::fields_t   fields,
    input  logic [13:0]        year_low,
    input  logic [13:0]        year_high,
    output dcs_pkg::result_t   result
);
    import dcs_pkg::*;

    logic               year_bad;
    logic               leap;
    logic [FIELD_W-1:0] month_days;
    logic [YEAR_W-1:0]  year_v;
    logic [FIELD_W-1:0] month_v;
    logic [FIELD_W-1:0] day_v;

    assign year_v  = fields.digit_faults[FAULT_YEAR]  ? '0 : fields.year;
    assign month_v = fields.digit_faults[FAULT_MONTH] ? '0 : fields.month;
    assign day_v   = fields.digit_faults[FAULT_DAY]   ? '0 : fields.day;

    assign year_bad = fields.digit_faults[FAULT_YEAR]
                   || (year_v < year_low) || (year_v > year_high);

    // A year is divisible by 4 when its last two digits are; a century year
    // is a leap year when its first two digits are divisible by 4.
    assign leap = (fields.year_in_century == '0) ? (fields.century[1:0] == 2'b00)
                                                 : (fields.year_in_century[1:0] == 2'b00);

    always_comb
    begin
        unique case (month_v)
            MONTH_FEB:                                    month_days = leap ? DAYS_FEB_LEAP
                                                                            : DAYS_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV:   month_days = DAYS_SHORT;
            default:                                      month_days = DAYS_LONG;
        endcase
    end

    always_comb
    begin
        result.year  = year_v;
        result.month = month_v;
        result.day   = day_v;
        if (fields.length != POS_END)
            result.status = STATUS_BAD_LEN;
        else if (fields.sep_fault)
            result.status = STATUS_BAD_SEP;
        else if (year_bad)
            result.status = STATUS_BAD_YEAR;
        else if (fields.digit_faults[FAULT_MONTH] || (month_v == '0)
                 || (month_v > MONTHS_PER_YEAR))
            result.status = STATUS_BAD_MONTH;
        else if (fields.digit_faults[FAULT_DAY] || (day_v == '0)
                 || (day_v > month_days))
            result.status = STATUS_BAD_DAY;
        else
            result.status = STATUS_VALID;
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import dcs_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PHASE_ITEMS = 160;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } text_char_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    cfg_index_t        cfg_index;
    logic [YEAR_W-1:0] cfg_data;

    dcs_char_if   char_if ();
    dcs_result_if res_if ();

    calendar_date_string_checker_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .char_in    (char_if),
        .result_out (res_if)
    );

    text_char_t pending_chars[$];
    result_t    expected_dates[$];

    // Copy of the year window and of the parse state, as the block should hold them.
    logic [YEAR_W-1:0]  window_low;
    logic [YEAR_W-1:0]  window_high;
    logic [POS_W-1:0]   pos_count;
    logic [YEAR_W-1:0]  year_acc;
    logic [FIELD_W-1:0] month_acc;
    logic [FIELD_W-1:0] day_acc;
    logic [2:0]         bad_digits;
    logic               bad_sep;

    int unsigned mismatch_count = 0;
    int unsigned results_checked = 0;
    int unsigned items_queued = 0;
    int unsigned idle_cycles = 0;
    logic        char_taken = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    int unsigned holds_done = 0;
    int unsigned mode_left = 0;
    int unsigned ready_mode = 0;
    logic [7:0]  stall_pattern = 8'b1011_0010;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [FIELD_W-1:0] days_in_month(input logic [FIELD_W-1:0] m,
                                                          input logic [YEAR_W-1:0] y);
        logic leap;
        leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        case (m)
            MONTH_FEB: return leap ? DAYS_FEB_LEAP : DAYS_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return DAYS_SHORT;
            default: return DAYS_LONG;
        endcase
    endfunction

    task automatic clear_parse();
        pos_count  = '0;
        year_acc   = '0;
        month_acc  = '0;
        day_acc    = '0;
        bad_digits = '0;
        bad_sep    = 1'b0;
    endtask

    // Folds one transferred character into the parse state; on the last character
    // it queues the date check that the block should report.
    task automatic fold_char(input logic [CHAR_W-1:0] ch, input logic is_last);
        logic               is_digit;
        logic [YEAR_W-1:0]  yv;
        logic [FIELD_W-1:0] mv;
        logic [FIELD_W-1:0] dv;
        result_t            r;
        is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        if (pos_count < POS_SEP1)
        begin
            if (is_digit)
                year_acc = year_acc * 14'd10 + YEAR_W'(ch - CHAR_ZERO);
            else
                bad_digits[FAULT_YEAR] = 1'b1;
        end
        else if (pos_count == POS_SEP1 || pos_count == POS_SEP2)
        begin
            if (ch != CHAR_DASH)
                bad_sep = 1'b1;
        end
        else if (pos_count < POS_SEP2)
        begin
            if (is_digit)
                month_acc = month_acc * 7'd10 + FIELD_W'(ch - CHAR_ZERO);
            else
                bad_digits[FAULT_MONTH] = 1'b1;
        end
        else if (pos_count < POS_END)
        begin
            if (is_digit)
                day_acc = day_acc * 7'd10 + FIELD_W'(ch - CHAR_ZERO);
            else
                bad_digits[FAULT_DAY] = 1'b1;
        end
        if (pos_count < POS_SAT)
            pos_count = pos_count + 1'b1;

        if (is_last)
        begin
            yv = bad_digits[FAULT_YEAR] ? '0 : year_acc;
            mv = bad_digits[FAULT_MONTH] ? '0 : month_acc;
            dv = bad_digits[FAULT_DAY] ? '0 : day_acc;
            if (pos_count != POS_END)
                r.status = STATUS_BAD_LEN;
            else if (bad_sep)
                r.status = STATUS_BAD_SEP;
            else if (bad_digits[FAULT_YEAR] || yv < window_low || yv > window_high)
                r.status = STATUS_BAD_YEAR;
            else if (bad_digits[FAULT_MONTH] || mv == '0 || mv > MONTHS_PER_YEAR)
                r.status = STATUS_BAD_MONTH;
            else if (bad_digits[FAULT_DAY] || dv == '0 || dv > days_in_month(mv, yv))
                r.status = STATUS_BAD_DAY;
            else
                r.status = STATUS_VALID;
            r.year  = yv;
            r.month = mv;
            r.day   = dv;
            expected_dates.push_back(r);
            clear_parse();
        end
    endtask

    function automatic logic [CHAR_W-1:0] ascii_digit(input int n);
        return CHAR_ZERO + CHAR_W'(n % 10);
    endfunction

    function automatic int pick_year();
        int y;
        case ($urandom_range(0, 7))
            0: y = int'(window_low) + int'($urandom_range(0, 2)) - 1;
            1: y = int'(window_high) + int'($urandom_range(0, 2)) - 1;
            2:
            begin
                case ($urandom_range(0, 4))
                    0: y = 1900;
                    1: y = 2000;
                    2: y = 2004;
                    3: y = 2100;
                    default: y = 2400;
                endcase
            end
            3: y = $urandom_range(0, 9999);
            default:
            begin
                if (window_low <= window_high && window_low <= 9999)
                    y = $urandom_range(window_low, (window_high > 9999) ? 9999 : window_high);
                else
                    y = $urandom_range(0, 9999);
            end
        endcase
        if (y < 0)
            y = 0;
        if (y > 9999)
            y = 9999;
        return y;
    endfunction

    function automatic int pick_month();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(13, 99);
            1, 2: return MONTH_FEB;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    function automatic int pick_day(input int m, input int y);
        int limit;
        limit = int'(days_in_month(FIELD_W'(m), YEAR_W'(y)));
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(32, 99);
            1: return limit + 1;
            2: return limit;
            default: return $urandom_range(1, limit);
        endcase
    endfunction

    task automatic push_char(input logic [CHAR_W-1:0] code, input logic is_last);
        text_char_t c;
        c.code    = code;
        c.is_last = is_last;
        pending_chars.push_back(c);
        items_queued++;
    endtask

    // Queues YYYY-MM-DD, optionally with one character overwritten by a random byte,
    // cut short, or followed by random bytes up to the given length.
    task automatic queue_date(input int y, input int m, input int d, input int corrupt,
                              input int len);
        logic [CHAR_W-1:0] text [16];
        text[0] = ascii_digit(y / 1000);
        text[1] = ascii_digit(y / 100);
        text[2] = ascii_digit(y / 10);
        text[3] = ascii_digit(y);
        text[4] = CHAR_DASH;
        text[5] = ascii_digit(m / 10);
        text[6] = ascii_digit(m);
        text[7] = CHAR_DASH;
        text[8] = ascii_digit(d / 10);
        text[9] = ascii_digit(d);
        for (int i = 10; i < len; i++)
            text[i] = CHAR_W'($urandom_range(0, 255));
        if (corrupt >= 0)
            text[corrupt] = CHAR_W'($urandom_range(0, 255));
        for (int i = 0; i < len; i++)
            push_char(text[i], i == len - 1);
    endtask

    task automatic queue_random_string();
        int kind;
        int y;
        int m;
        int d;
        int len;
        kind = $urandom_range(0, 99);
        y = pick_year();
        m = pick_month();
        d = pick_day(m, y);
        if (kind < 60)
            queue_date(y, m, d, -1, 10);
        else if (kind < 75)
            queue_date(y, m, d, $urandom_range(0, 9), 10);
        else if (kind < 88)
        begin
            len = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 9) : $urandom_range(11, 16);
            queue_date(y, m, d, -1, len);
        end
        else
        begin
            len = $urandom_range(1, 14);
            for (int i = 0; i < len; i++)
                push_char(CHAR_W'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned start;
        start = items_queued;
        while (items_queued - start < count)
            queue_random_string();
    endtask

    task automatic drain(input int unsigned settle);
        while (pending_chars.size() != 0 || expected_dates.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_year_window(input logic [YEAR_W-1:0] lo, input logic [YEAR_W-1:0] hi);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_YEAR_LOW;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= CFG_YEAR_HIGH;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        window_low  = lo;
        window_high = hi;
    endtask

    task automatic run_phase(input logic [YEAR_W-1:0] lo, input logic [YEAR_W-1:0] hi);
        set_year_window(lo, hi);
        run_random(PHASE_ITEMS);
        drain(4);
    endtask

    initial
    begin
        int unsigned lo;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = CFG_YEAR_LOW;
        cfg_data          = '0;
        char_if.valid     = 1'b0;
        char_if.char_code = '0;
        char_if.last_char = 1'b0;
        res_if.ready      = 1'b0;
        window_low        = YEAR_LOW_RESET;
        window_high       = YEAR_HIGH_RESET;
        clear_parse();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Leap day of a century divisible by 400, lone non-digits, an overlong string.
        queue_date(2000, 2, 29, -1, 10);
        push_char(8'hFF, 1'b1);
        queue_date(1999, 13, 0, -1, 12);
        push_char(8'h00, 1'b1);
        run_random(PHASE_ITEMS);
        drain(4);

        run_phase(14'd0, 14'd9999);
        run_phase(14'd9999, 14'd16383);
        run_phase(14'd2100, 14'd1900);
        run_phase(14'd0, 14'd0);
        run_phase(14'd16383, 14'd16383);
        run_phase(14'd1583, 14'd2399);
        lo = $urandom_range(0, 5000);
        run_phase(YEAR_W'(lo), YEAR_W'(lo + $urandom_range(0, 4999)));
        run_phase(YEAR_W'($urandom_range(0, 16383)), YEAR_W'($urandom_range(0, 16383)));

        drain(10);
        if (mismatch_count == 0)
            $display("calendar_date_string_checker_core: match");
        else
            $display("calendar_date_string_checker_core: mismatch");
        $finish;
    end

    // Character sender: holds an offer until it is taken, works in bursts with gaps.
    always @(negedge clk)
    begin
        if (rst_n && !(char_if.valid && !char_taken))
        begin
            char_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                char_if.valid <= 1'b0;
            end
            else if (pending_chars.size() > 0)
            begin
                char_if.valid     <= 1'b1;
                char_if.char_code <= pending_chars[0].code;
                char_if.last_char <= pending_chars[0].is_last;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 32);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                char_if.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && char_if.valid && char_if.ready)
        begin
            fold_char(char_if.char_code, char_if.last_char);
            void'(pending_chars.pop_front());
            char_taken = 1'b1;
        end
    end

    // Result receiver: stall mode changes every so often; at most twice it holds off for a
    // long stretch while plenty of characters are still waiting.
    always @(negedge clk)
    begin
        logic rdy;
        if (rst_n)
        begin
            if (hold_left == 0 && holds_done < 2 && results_checked >= 30 + 70 * holds_done
                && pending_chars.size() > 40)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 128);
            end
            else
                mode_left--;
            stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
            case (ready_mode)
                0: rdy = 1'b1;
                1: rdy = $urandom_range(0, 1);
                2: rdy = stall_pattern[0];
                default: rdy = ($urandom_range(0, 3) == 0);
            endcase
            if (hold_left > 0)
            begin
                rdy = 1'b0;
                hold_left--;
            end
            res_if.ready <= rdy;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_checked++;
            if (expected_dates.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result transfer with none expected: status=%0d year=%0d month=%0d day=%0d",
                         $time, res_if.status, res_if.year_value, res_if.month_value,
                         res_if.day_value);
            end
            else
            begin
                want = expected_dates.pop_front();
                if (res_if.status !== want.status || res_if.year_value !== want.year
                    || res_if.month_value !== want.month || res_if.day_value !== want.day)
                begin
                    mismatch_count++;
                    $display("%0t: expected status=%0d year=%0d month=%0d day=%0d, got status=%0d year=%0d month=%0d day=%0d",
                             $time, want.status, want.year, want.month, want.day,
                             res_if.status, res_if.year_value, res_if.month_value,
                             res_if.day_value);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (char_if.valid && char_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("calendar_date_string_checker_core: mismatch");
            $finish;
        end
    end

endmodule
